FILE: design/lane_crossing_counter_unit_assert.svh
// Assertion macros for the lane crossing counter.
// Each macro samples on clk and is disabled while rst is high.
`ifndef LANE_CROSSING_COUNTER_UNIT_ASSERT_SVH
`define LANE_CROSSING_COUNTER_UNIT_ASSERT_SVH

// The condition implies the expression in the same cycle.
`define LCC_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// The condition implies the expression in the following cycle.
`define LCC_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: design/lcc_pkg.sv
`timescale 1ns / 1ps

package lcc_pkg;

  localparam int LANES      = 10;
  localparam int COUNT_BITS = 16;
  localparam int ADDR_BITS  = (LANES > 1) ? $clog2(LANES) : 1;

  localparam int LANE_W  = 4;
  localparam int WSUM_W  = 27;
  localparam int RSUM_W  = 36;
  localparam int ROW_W   = 11;
  localparam int TOTAL_W = 16;
  localparam int STEP_W  = $clog2(RSUM_W);

  localparam int GATE_W   = 9;
  localparam int MARGIN_W = 8;
  localparam int AREA_W   = 27;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  localparam logic [CFG_IDX_W-1:0] REG_GATE_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_BOTTOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA    = 2'd3;

  localparam logic [GATE_W-1:0]   GATE_TOP_RST    = 9'd300;
  localparam logic [GATE_W-1:0]   GATE_BOTTOM_RST = 9'd330;
  localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST = 8'd30;
  localparam logic [AREA_W-1:0]   MIN_AREA_RST    = 27'd400;

  localparam logic [11:0] ROW_MAX = 12'd960;

  typedef logic signed [ROW_W-1:0] row_t;

  localparam row_t ROW_UNSEEN = -11'sd1;

  typedef struct packed {
    row_t last_row;
    row_t prior_row;
    logic counted;
  } lane_rec_t;

  localparam lane_rec_t LANE_REC_RST = '{last_row: ROW_UNSEEN, prior_row: '0, counted: 1'b0};

endpackage

FILE: design/lane_crossing_counter_unit.sv
`timescale 1ns / 1ps

// Lane crossing counter. Software writes the gate rows, edge margin and
// minimum area through the cfg_write port while the unit is idle. Each item
// is accepted at a rising edge with start high and busy low. A measurement
// item reads its lane record from a small synchronous memory, decides
// whether the lane counted an entry or an exit, and, when the object is
// large enough, divides the row-weighted sum by the intensity sum to find
// the new tracked row. A clear item returns both totals and zeroes them.
// Every item produces exactly one result beat, shown for a single cycle
// with done high; the receiver cannot stall, so results must be captured
// on that cycle. Clear items and lanes out of range raise done as they
// leave the evaluation state; measurements whose intensity sum does not
// exceed min_area raise it in the write-back state. Items that update
// tracking pass through evaluation, which evaluates the lane and starts
// the divider, the divider state, which runs the restoring steps and
// takes the quotient, and write-back, which writes the record back. The
// next item can be accepted in the cycle in which done is high. The lane
// memory needs no clearing pass: a valid flag per lane, cleared by reset,
// makes an unwritten lane read as never seen.
module lane_crossing_counter_unit import lcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode,
  input  logic [LANE_W-1:0]     lane,
  input  logic [WSUM_W-1:0]     weight_sum,
  input  logic [RSUM_W-1:0]     row_weight_sum,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic                  entry_event,
  output logic                  exit_event,
  output logic [TOTAL_W-1:0]    entry_total,
  output logic [TOTAL_W-1:0]    exit_total,
  output row_t                  tracked_row
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0] state;

  // Configuration registers.
  logic [GATE_W-1:0]   gate_top;
  logic [GATE_W-1:0]   gate_bottom;
  logic [MARGIN_W-1:0] edge_margin;
  logic [AREA_W-1:0]   min_area;

  // Lane records live in a one-port-read, one-port-write memory.
  lane_rec_t lane_mem [LANES];
  logic      lane_valid [LANES];

  logic [COUNT_BITS-1:0] entry_count;
  logic [COUNT_BITS-1:0] exit_count;

  // Item held for the duration of its work.
  logic                 mode_q;
  logic [LANE_W-1:0]    lane_q;
  logic [WSUM_W-1:0]    wsum_q;
  logic [RSUM_W-1:0]    rsum_q;
  lane_rec_t            rd_rec;
  logic                 rd_valid;
  lane_rec_t            work_rec;
  logic                 ent_q;
  logic                 ext_q;

  logic                 accept;
  logic [ADDR_BITS-1:0] lane_addr;
  logic [ADDR_BITS-1:0] lane_addr_q;

  lane_rec_t         cur_rec;
  logic signed [11:0] t_w;
  logic signed [11:0] top_m;
  logic signed [11:0] bot_m;
  logic              in_range;
  logic              big_enough;
  logic              exit_hit;
  logic              entry_hit;
  logic              rearm;
  logic              counted_next;

  logic              div_go;
  logic              div_active;
  logic              div_done;
  logic [RSUM_W-1:0] div_quo;
  logic [11:0]       row_sum;
  row_t              sat_row;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    return (c != '1) ? c + 1'b1 : c;
  endfunction

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign lane_addr   = ADDR_BITS'(lane);
  assign lane_addr_q = ADDR_BITS'(lane_q);

  // A lane that was never written reads as its reset record.
  assign cur_rec = rd_valid ? rd_rec : LANE_REC_RST;

  // Zone limits are compared in full signed precision, since the lower
  // re-arm limit can go below zero.
  assign t_w   = 12'(cur_rec.last_row);
  assign top_m = signed'({3'b000, gate_top} + {4'b0000, edge_margin});
  assign bot_m = signed'({3'b000, gate_bottom} - {4'b0000, edge_margin});

  assign in_range   = 32'(lane_q) < LANES;
  assign big_enough = wsum_q > min_area;

  // Moving up near the top line is an exit; moving down near the bottom
  // line is an entry. Both need an armed lane and the two directions exclude each other, so at most one fires.
  assign exit_hit  = (cur_rec.prior_row > cur_rec.last_row) && (t_w < top_m)
                     && !cur_rec.counted;
  assign entry_hit = (cur_rec.prior_row < cur_rec.last_row) && (t_w > bot_m)
                     && !cur_rec.counted;
  assign rearm     = (t_w > top_m) && (t_w < bot_m);
  assign counted_next = rearm ? 1'b0 : (cur_rec.counted || exit_hit || entry_hit);

  assign div_go = (state == S_EVAL) && !mode_q && in_range && big_enough;

  lcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (rsum_q),
    .divisor  (wsum_q),
    .active   (div_active),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Centroid row plus the gate offset, clipped at the frame limit.
  assign row_sum = {2'b00, div_quo[9:0]} + {3'b000, gate_top};
  always_comb begin
    if ((|div_quo[RSUM_W-1:10]) || (row_sum > ROW_MAX)) begin
      sat_row = row_t'(ROW_MAX);
    end else begin
      sat_row = row_t'(row_sum);
    end
  end

  // Control state, counters, valid flags and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      entry_count <= '0;
      exit_count  <= '0;
      gate_top    <= GATE_TOP_RST;
      gate_bottom <= GATE_BOTTOM_RST;
      edge_margin <= EDGE_MARGIN_RST;
      min_area    <= MIN_AREA_RST;
      for (int i = 0; i < LANES; i++) begin
        lane_valid[i] <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GATE_TOP:    gate_top    <= cfg_data[GATE_W-1:0];
          REG_GATE_BOTTOM: gate_bottom <= cfg_data[GATE_W-1:0];
          REG_EDGE_MARGIN: edge_margin <= cfg_data[MARGIN_W-1:0];
          REG_MIN_AREA:    min_area    <= cfg_data[AREA_W-1:0];
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (mode_q) begin
            entry_count <= '0;
            exit_count  <= '0;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else if (!in_range) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (entry_hit) begin
              entry_count <= bump(entry_count);
            end
            if (exit_hit) begin
              exit_count <= bump(exit_count);
            end
            state <= big_enough ? S_DIV : S_WB;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          lane_valid[lane_addr_q] <= 1'b1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item payload, memory access and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          mode_q   <= mode;
          lane_q   <= lane;
          wsum_q   <= weight_sum;
          rsum_q   <= row_weight_sum;
          rd_rec   <= lane_mem[lane_addr];
          rd_valid <= lane_valid[lane_addr];
        end
      end
      S_EVAL: begin
        if (mode_q) begin
          entry_event <= 1'b0;
          exit_event  <= 1'b0;
          entry_total <= TOTAL_W'(entry_count);
          exit_total  <= TOTAL_W'(exit_count);
          tracked_row <= '0;
        end else if (!in_range) begin
          entry_event <= 1'b0;
          exit_event  <= 1'b0;
          entry_total <= TOTAL_W'(entry_count);
          exit_total  <= TOTAL_W'(exit_count);
          tracked_row <= ROW_UNSEEN;
        end else begin
          work_rec.last_row  <= cur_rec.last_row;
          work_rec.prior_row <= cur_rec.last_row;
          work_rec.counted   <= counted_next;
          ent_q              <= entry_hit;
          ext_q              <= exit_hit;
        end
      end
      S_DIV: begin
        if (div_done) begin
          work_rec.last_row <= sat_row;
        end
      end
      S_WB: begin
        lane_mem[lane_addr_q] <= work_rec;
        entry_event <= ent_q;
        exit_event  <= ext_q;
        entry_total <= TOTAL_W'(entry_count);
        exit_total  <= TOTAL_W'(exit_count);
        tracked_row <= work_rec.last_row;
      end
      default: begin
      end
    endcase
  end

  // Checks on the unit's own sequencing.
  `include "lane_crossing_counter_unit_assert.svh"

  `LCC_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "accepted item did not raise busy")
  `LCC_ASSERT_NOW(a_done_idle, done, !busy, "result beat shown while still busy")
  `LCC_ASSERT_NOW(a_one_event, done, !(entry_event && exit_event), "entry and exit in one beat")
  `LCC_ASSERT_NOW(a_div_free, div_go, !div_active && (state == S_EVAL), "divider restarted while in use")

endmodule

FILE: design/lcc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module lcc_div import lcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [RSUM_W-1:0] dividend,
  input  logic [WSUM_W-1:0] divisor,
  output logic              active,
  output logic              done,
  output logic [RSUM_W-1:0] quotient
);

  logic [STEP_W-1:0] step_cnt;
  logic [WSUM_W-1:0] rem;
  logic [RSUM_W-1:0] quo;
  logic [WSUM_W-1:0] dsr;
  logic [WSUM_W:0]   shifted;
  logic [WSUM_W:0]   diff;
  logic              fits;

  assign shifted  = {rem, quo[RSUM_W-1]};
  assign diff     = shifted - {1'b0, dsr};
  assign fits     = shifted >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active   <= 1'b1;
        step_cnt <= STEP_W'(RSUM_W - 1);
      end else if (active) begin
        if (step_cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          step_cnt <= step_cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (active) begin
      rem <= fits ? diff[WSUM_W-1:0] : shifted[WSUM_W-1:0];
      quo <= {quo[RSUM_W-2:0], fits};
    end
  end

endmodule
